// ===== rtl/ccl_pkg.sv =====
// Shared types, constants and helper functions for the character canvas line fill block.
// Used by ccl_seq, the top level and the bench, but not by ccl_ram; depends on nothing else.
`timescale 1ns / 1ps

package ccl_pkg;

    // Canvas store dimensions.
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int STORE_CELLS = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;

    // Field widths fixed by the interface.
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 8;
    localparam int CFG_W    = 7;
    // Walking coordinate: start position plus up to 254 steps, signed.
    localparam int COORD_W  = 10;
    // Limits hold up to 511.
    localparam int LIM_W    = 9;

    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h2E;
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_CELLS - 1);

    // Action codes.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Direction codes.
    localparam logic [1:0] DIR_HORIZ = 2'd1;
    localparam logic [1:0] DIR_VERT  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Canvas size in use, already limited to the store size.
    typedef struct packed {
        logic [LIM_W-1:0] rows;
        logic [LIM_W-1:0] cols;
    } t_canvas_lim;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // True when a signed coordinate lies inside the canvas in use.
    function automatic logic in_canvas(
        input logic signed [COORD_W-1:0] row,
        input logic signed [COORD_W-1:0] col,
        input t_canvas_lim               lim
    );
        logic row_ok;
        logic col_ok;
        row_ok = !row[COORD_W-1] && (LIM_W'(row[COORD_W-2:0]) < lim.rows);
        col_ok = !col[COORD_W-1] && (LIM_W'(col[COORD_W-2:0]) < lim.cols);
        return row_ok && col_ok;
    endfunction

    // Store address of a cell; only meaningful for cells inside the canvas.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic signed [COORD_W-1:0] row,
        input logic signed [COORD_W-1:0] col
    );
        logic [ADDR_W-1:0] row_part;
        logic [ADDR_W-1:0] col_part;
        row_part = ADDR_W'(row[COORD_W-2:0]);
        col_part = ADDR_W'(col[COORD_W-2:0]);
        return ADDR_W'(row_part * ADDR_W'(MAX_COLS)) + col_part;
    endfunction

    // Clamp a configuration value to a store dimension.
    function automatic logic [LIM_W-1:0] clamp_lim(
        input logic [CFG_W-1:0] value,
        input logic [LIM_W-1:0] max_value
    );
        return (LIM_W'(value) > max_value) ? max_value : LIM_W'(value);
    endfunction

endpackage

// ===== rtl/ccl_ram.sv =====
// Simple dual-port synchronous RAM holding the canvas cells.
// One write port and one read port with registered read data; no package dependency.
`timescale 1ns / 1ps

module ccl_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data appears in the cycle after the request and then holds.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ccl_seq.sv =====
// Item sequencer: walks clears and runs over the canvas store and answers reads.
// Depends on ccl_pkg for types, codes and address helpers; drives the ccl_ram ports.
`timescale 1ns / 1ps

module ccl_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ccl_pkg::t_canvas_lim          i_lim,
    // Item channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [ccl_pkg::CHAR_W-1:0]    i_fill_char,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_row,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_col,
    input  logic [1:0]                    i_direction,
    input  logic [ccl_pkg::LEN_W-1:0]     i_run_length,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ccl_pkg::CHAR_W-1:0]    o_cell_char,
    output logic                          o_in_range,
    // Memory side
    output ccl_pkg::t_mem_req             o_mem,
    input  logic [ccl_pkg::CHAR_W-1:0]    i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_DRAW  = 4'b0100,
        S_READ  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic signed [ccl_pkg::COORD_W-1:0] r_row, n_row;
    logic signed [ccl_pkg::COORD_W-1:0] r_col, n_col;
    logic [ccl_pkg::LEN_W-1:0]          r_cnt, n_cnt;
    logic [1:0]                         r_dir, n_dir;
    logic [ccl_pkg::CHAR_W-1:0]         r_char, n_char;
    logic [ccl_pkg::ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic                               r_rd_in, n_rd_in;

    logic                               r_out_valid, n_out_valid;
    logic [ccl_pkg::CHAR_W-1:0]         r_out_char, n_out_char;
    logic                               r_out_in, n_out_in;

    logic                               accept;
    logic signed [ccl_pkg::COORD_W-1:0] in_row;
    logic signed [ccl_pkg::COORD_W-1:0] in_col;
    logic                               draw_in;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign in_row  = ccl_pkg::COORD_W'(i_start_row);
    assign in_col  = ccl_pkg::COORD_W'(i_start_col);
    assign draw_in = ccl_pkg::in_canvas(r_row, r_col, i_lim);

    // Next-state logic and memory requests.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_cnt       = r_cnt;
        n_dir       = r_dir;
        n_char      = r_char;
        n_clr_addr  = r_clr_addr;
        n_rd_in     = r_rd_in;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_in    = r_out_in;
        o_mem       = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_row  = in_row;
                    n_col  = in_col;
                    n_dir  = i_direction;
                    n_char = i_fill_char;
                    case (i_action)
                        ccl_pkg::ACT_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        ccl_pkg::ACT_DRAW: begin
                            if (i_direction == ccl_pkg::DIR_HORIZ ||
                                i_direction == ccl_pkg::DIR_VERT) begin
                                n_cnt = i_run_length;
                            end else begin
                                n_cnt = ccl_pkg::LEN_W'(1);
                            end
                            if (n_cnt != '0) begin
                                n_state = S_DRAW;
                            end
                        end
                        ccl_pkg::ACT_READ: begin
                            // Start the read now; data comes back next cycle.
                            n_rd_in     = ccl_pkg::in_canvas(in_row, in_col, i_lim);
                            o_mem.re    = 1'b1;
                            o_mem.raddr = ccl_pkg::cell_addr(in_row, in_col);
                            n_state     = S_READ;
                        end
                        default: begin
                            // Unused action: the transaction is dropped.
                        end
                    endcase
                end
            end

            S_CLEAR: begin
                // Sweep every entry of the store, one a cycle.
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_addr;
                o_mem.wdata = ccl_pkg::BLANK_CHAR;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == ccl_pkg::LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end

            S_DRAW: begin
                // One cell of the run per cycle; cells off the canvas are skipped.
                o_mem.we    = draw_in;
                o_mem.waddr = ccl_pkg::cell_addr(r_row, r_col);
                o_mem.wdata = r_char;
                if (r_dir == ccl_pkg::DIR_VERT) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == ccl_pkg::LEN_W'(1)) begin
                    n_state = S_IDLE;
                end
            end

            S_READ: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_char  = r_rd_in ? i_rdata : '0;
                    n_out_in    = r_rd_in;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_cnt      <= n_cnt;
        r_dir      <= n_dir;
        r_char     <= n_char;
        r_clr_addr <= n_clr_addr;
        r_rd_in    <= n_rd_in;
        r_out_char <= n_out_char;
        r_out_in   <= n_out_in;
    end

    assign o_valid     = r_out_valid;
    assign o_cell_char = r_out_char;
    assign o_in_range  = r_out_in;

endmodule

// ===== rtl/char_canvas_line_fill.sv =====
// Top level of the character canvas line fill block.
// Holds the canvas size registers and connects ccl_seq to ccl_ram; depends on ccl_pkg.
//
// Usage:
//   Items arrive on i_valid/o_ready with action, fill character, signed start
//   row and column, direction and run length. A transaction is taken when
//   both are high. Only a read item produces a result, on o_valid/i_ready,
//   carrying the cell character and an in-range flag.
//   Canvas size is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
//   index 0 sets the rows in use, index 1 the columns, each limited to the
//   store size.
//   Work per item once it is taken:
//     clear: one write per store entry, over all 4096 entries;
//     draw:  one write per cell of the run, up to 255 cells (one for a
//            single cell, none for an empty run);
//     read:  the RAM read, then the load of the result into the output
//            register once it is free, which then drives o_valid.
//   One item is in work at a time; o_ready is high only between items.
//   A read result waits in an output register while i_ready is low; the
//   block holds further items off only if a second read is then waiting to load.
//   Reset returns the sequencer to idle, drops any pending result and sets
//   the canvas to 64 by 64. Canvas contents are undefined until a clear.
`timescale 1ns / 1ps

module char_canvas_line_fill (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ccl_pkg::CFG_W-1:0]        i_cfg_data,
    // Item channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_action,
    input  logic [ccl_pkg::CHAR_W-1:0]       i_fill_char,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_row,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_col,
    input  logic [1:0]                       i_direction,
    input  logic [ccl_pkg::LEN_W-1:0]        i_run_length,
    // Result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ccl_pkg::CHAR_W-1:0]       o_cell_char,
    output logic                             o_in_range
);

    localparam logic [ccl_pkg::LIM_W-1:0] ROWS_MAX = ccl_pkg::LIM_W'(ccl_pkg::MAX_ROWS);
    localparam logic [ccl_pkg::LIM_W-1:0] COLS_MAX = ccl_pkg::LIM_W'(ccl_pkg::MAX_COLS);
    localparam logic [ccl_pkg::CFG_W-1:0] CFG_RESET = ccl_pkg::CFG_W'(64);

    ccl_pkg::t_canvas_lim r_lim, n_lim;
    ccl_pkg::t_mem_req    mem_req;
    logic [ccl_pkg::CHAR_W-1:0] rdata;

    // Canvas size registers, stored already clamped to the store size.
    always_comb begin
        n_lim = r_lim;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ccl_pkg::CFG_ROWS: n_lim.rows = ccl_pkg::clamp_lim(i_cfg_data, ROWS_MAX);
                ccl_pkg::CFG_COLS: n_lim.cols = ccl_pkg::clamp_lim(i_cfg_data, COLS_MAX);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.rows <= ccl_pkg::clamp_lim(CFG_RESET, ROWS_MAX);
            r_lim.cols <= ccl_pkg::clamp_lim(CFG_RESET, COLS_MAX);
        end else begin
            r_lim <= n_lim;
        end
    end

    // Sequencer.
    ccl_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lim        (r_lim),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_fill_char  (i_fill_char),
        .i_start_row  (i_start_row),
        .i_start_col  (i_start_col),
        .i_direction  (i_direction),
        .i_run_length (i_run_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_char  (o_cell_char),
        .o_in_range   (o_in_range),
        .o_mem        (mem_req),
        .i_rdata      (rdata)
    );

    // Canvas store.
    ccl_ram #(
        .DATA_W (ccl_pkg::CHAR_W),
        .DEPTH  (ccl_pkg::STORE_CELLS),
        .ADDR_W (ccl_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

endmodule

// ===== bench/ccl_read_checker.sv =====
// Checker for the character canvas line fill block: follows both channels and the size port.
// Keeps its own canvas and expected read results; depends on ccl_pkg only.
`timescale 1ns / 1ps

module ccl_read_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [ccl_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_item_valid,
    input  logic                             i_item_ready,
    input  logic [1:0]                       i_action,
    input  logic [ccl_pkg::CHAR_W-1:0]       i_fill_char,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_row,
    input  logic signed [ccl_pkg::POS_W-1:0] i_start_col,
    input  logic [1:0]                       i_direction,
    input  logic [ccl_pkg::LEN_W-1:0]        i_run_length,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [ccl_pkg::CHAR_W-1:0]       i_cell_char,
    input  logic                             i_in_range,
    output int                               o_fail_count,
    output int                               o_pending
);
    import ccl_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              in_range;
    } t_read_result;

    // Shadow copy of the canvas store and of the two size registers.
    logic [CHAR_W-1:0] canvas_cells [STORE_CELLS];
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    t_read_result      expected_reads [$];
    int                fail_total;

    initial begin
        fail_total   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Sizes in use, limited to the store dimensions.
    function automatic int rows_limit();
        return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int cols_limit();
        return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic bit on_canvas(int row, int col);
        return row >= 0 && row < rows_limit() && col >= 0 && col < cols_limit();
    endfunction

    // Cells off the canvas in use are dropped without notice.
    task automatic paint_cell(int row, int col, logic [CHAR_W-1:0] ch);
        if (on_canvas(row, col)) begin
            canvas_cells[row * MAX_COLS + col] = ch;
        end
    endtask

    // Applies one accepted item to the shadow canvas and queues any read result.
    task automatic apply_item(
        input logic [1:0]              action,
        input logic [CHAR_W-1:0]       ch,
        input logic signed [POS_W-1:0] row0,
        input logic signed [POS_W-1:0] col0,
        input logic [1:0]              dir,
        input logic [LEN_W-1:0]        len
    );
        int           row;
        int           col;
        int           count;
        int           k;
        t_read_result res;
        row   = int'(row0);
        col   = int'(col0);
        count = int'(len);
        case (action)
            ACT_CLEAR: begin
                // The whole store is blanked, not just the canvas in use.
                for (k = 0; k < STORE_CELLS; k++) begin
                    canvas_cells[k] = BLANK_CHAR;
                end
            end
            ACT_DRAW: begin
                if (dir == DIR_HORIZ) begin
                    for (k = 0; k < count; k++) begin
                        paint_cell(row, col + k, ch);
                    end
                end else if (dir == DIR_VERT) begin
                    for (k = 0; k < count; k++) begin
                        paint_cell(row + k, col, ch);
                    end
                end else begin
                    // Single cell and the spare direction code ignore the length.
                    paint_cell(row, col, ch);
                end
            end
            ACT_READ: begin
                if (on_canvas(row, col)) begin
                    res.cell_char = canvas_cells[row * MAX_COLS + col];
                    res.in_range  = 1'b1;
                end else begin
                    res.cell_char = '0;
                    res.in_range  = 1'b0;
                end
                expected_reads.push_back(res);
            end
            default: begin
                // The spare action code is ignored.
            end
        endcase
    endtask

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Everything is sampled at the rising edge, where the stimulus is stable.
    always @(posedge i_clk) begin
        t_read_result got;
        t_read_result want;
        if (!i_rst_n) begin
            rows_reg = CFG_W'(MAX_ROWS);
            cols_reg = CFG_W'(MAX_COLS);
            expected_reads.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_ROWS) begin
                    rows_reg = i_cfg_data;
                end else begin
                    cols_reg = i_cfg_data;
                end
            end
            if (i_item_valid && i_item_ready) begin
                apply_item(i_action, i_fill_char, i_start_row, i_start_col,
                           i_direction, i_run_length);
            end
            if (i_res_valid && i_res_ready) begin
                got.cell_char = i_cell_char;
                got.in_range  = i_in_range;
                if (expected_reads.size() == 0) begin
                    note_failure($sformatf("unexpected read result: char %02h in_range %0b",
                                           got.cell_char, got.in_range));
                end else begin
                    want = expected_reads.pop_front();
                    if (got.cell_char !== want.cell_char) begin
                        note_failure($sformatf("cell_char: expected %02h, got %02h",
                                               want.cell_char, got.cell_char));
                    end
                    if (got.in_range !== want.in_range) begin
                        note_failure($sformatf("in_range: expected %0b, got %0b",
                                               want.in_range, got.in_range));
                    end
                end
            end
        end
        o_pending    = expected_reads.size();
        o_fail_count = fail_total;
    end

endmodule

// ===== bench/char_canvas_line_fill_test.sv =====
// Testbench top for the character canvas line fill block: clock, reset, stimulus and verdict.
// Depends on ccl_pkg, the block itself and ccl_read_checker.
`timescale 1ns / 1ps

module char_canvas_line_fill_test;
    import ccl_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0] ACT_SPARE  = 2'd3;
    localparam logic [1:0] DIR_SINGLE = 2'd0;
    localparam logic [1:0] DIR_SPARE  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_H = "h";
    localparam logic [CHAR_W-1:0] CH_V = "v";
    localparam logic [CHAR_W-1:0] CH_Z = "Z";

    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 145;
    // A clear walks the whole store, so this covers the slowest item.
    localparam int SETTLE_CYCLES = 4200;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic                       i_cfg_idx;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic [1:0]                 i_action;
    logic [CHAR_W-1:0]          i_fill_char;
    logic signed [POS_W-1:0]    i_start_row;
    logic signed [POS_W-1:0]    i_start_col;
    logic [1:0]                 i_direction;
    logic [LEN_W-1:0]           i_run_length;
    logic                       o_valid;
    logic                       i_ready;
    logic [CHAR_W-1:0]          o_cell_char;
    logic                       o_in_range;

    int fail_count;
    int pending;
    // When set, neither side inserts gaps.
    bit steady;
    int rows_now;
    int cols_now;

    // Canvas sizes for the first phases; later phases pick at random.
    int row_plan [PHASES] = '{64, 1, 0, 7, 127, 64, 1, 13, 65, 0, 0, 0};
    int col_plan [PHASES] = '{64, 1, 5, 0, 100, 1, 64, 29, 127, 0, 0, 0};

    char_canvas_line_fill u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_fill_char  (i_fill_char),
        .i_start_row  (i_start_row),
        .i_start_col  (i_start_col),
        .i_direction  (i_direction),
        .i_run_length (i_run_length),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cell_char  (o_cell_char),
        .o_in_range   (o_in_range)
    );

    ccl_read_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (i_valid),
        .i_item_ready (o_ready),
        .i_action     (i_action),
        .i_fill_char  (i_fill_char),
        .i_start_row  (i_start_row),
        .i_start_col  (i_start_col),
        .i_direction  (i_direction),
        .i_run_length (i_run_length),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_cell_char  (o_cell_char),
        .i_in_range   (o_in_range),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #20_000_000;
        $display("char_canvas_line_fill_test NOT OK");
        $finish;
    end

    // Result side: a random stall before each transaction, none while steady.
    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Presents one item after a random gap (none while steady) and holds it until it is taken.
    task automatic send_item(
        input logic [1:0]              action,
        input logic [CHAR_W-1:0]       ch,
        input logic signed [POS_W-1:0] row,
        input logic signed [POS_W-1:0] col,
        input logic [1:0]              dir,
        input logic [LEN_W-1:0]        len
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= action;
        i_fill_char  <= ch;
        i_start_row  <= row;
        i_start_col  <= col;
        i_direction  <= dir;
        i_run_length <= len;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // A read carries random noise in the fields it does not use.
    task automatic read_cell(input logic signed [POS_W-1:0] row,
                             input logic signed [POS_W-1:0] col);
        send_item(ACT_READ, 8'($urandom), row, col, 2'($urandom), 8'($urandom));
    endtask

    // Stops sending and waits until every expected read result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Size registers change only once the block has gone quiet.
    task automatic set_canvas(input int rows, input int cols);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ROWS;
        i_cfg_data <= CFG_W'(rows);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_COLS;
        i_cfg_data <= CFG_W'(cols);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        rows_now = rows;
        cols_now = cols;
    endtask

    // One random item, with coordinates and lengths mostly near the canvas in use.
    task automatic random_item(output bit counted);
        int                      span_r;
        int                      span_c;
        int                      span;
        int                      pick;
        logic [1:0]              action;
        logic signed [POS_W-1:0] row;
        logic signed [POS_W-1:0] col;
        logic [LEN_W-1:0]        len;
        span_r = (rows_now > MAX_ROWS) ? MAX_ROWS : rows_now;
        span_c = (cols_now > MAX_COLS) ? MAX_COLS : cols_now;
        span   = (span_r > span_c) ? span_r : span_c;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            action = ACT_CLEAR;
        end else if (pick < 5) begin
            action = ACT_SPARE;
        end else if (pick < 52) begin
            action = ACT_DRAW;
        end else begin
            action = ACT_READ;
        end
        if ($urandom_range(0, 9) == 0) begin
            row = 8'($urandom);
            col = 8'($urandom);
        end else begin
            row = 8'($urandom_range(0, span_r + 6) - 3);
            col = 8'($urandom_range(0, span_c + 6) - 3);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            len = 8'hFF;
        end else if (pick == 1) begin
            len = 8'($urandom);
        end else begin
            len = 8'($urandom_range(0, span + 4));
        end
        send_item(action, 8'($urandom), row, col, 2'($urandom_range(0, 3)), len);
        counted = (action != ACT_SPARE);
    endtask

    initial begin
        int  phase;
        int  done;
        bit  counted;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_ROWS;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_action     = ACT_CLEAR;
        i_fill_char  = '0;
        i_start_row  = '0;
        i_start_col  = '0;
        i_direction  = DIR_SINGLE;
        i_run_length = '0;
        steady       = 1'b0;
        rows_now     = MAX_ROWS;
        cols_now     = MAX_COLS;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the 64 by 64 canvas left by reset.
        // A draw before the first clear still lands, and can be read back.
        send_item(ACT_DRAW, CH_Z, 8'sd3, 8'sd5, DIR_SINGLE, 8'd0);
        read_cell(8'sd3, 8'sd5);
        read_cell(-8'sd1, 8'sd0);
        send_item(ACT_CLEAR, 8'h00, 8'sd0, 8'sd0, DIR_SINGLE, 8'd0);
        read_cell(8'sd0, 8'sd0);
        // Horizontal run clipped on the left.
        send_item(ACT_DRAW, 8'hFF, 8'sd0, -8'sd3, DIR_HORIZ, 8'd10);
        read_cell(8'sd0, 8'sd6);
        read_cell(8'sd0, 8'sd7);
        // Longest vertical run, clipped at the bottom.
        send_item(ACT_DRAW, 8'h00, 8'sd60, 8'sd63, DIR_VERT, 8'd255);
        read_cell(8'sd63, 8'sd63);
        // Single cell ignores the length, and so does the spare direction.
        send_item(ACT_DRAW, CH_H, 8'sd10, 8'sd10, DIR_SINGLE, 8'd200);
        read_cell(8'sd10, 8'sd11);
        read_cell(8'sd10, 8'sd10);
        send_item(ACT_DRAW, CH_V, 8'sd20, 8'sd20, DIR_SPARE, 8'd50);
        read_cell(8'sd21, 8'sd20);
        read_cell(8'sd20, 8'sd20);
        // The spare action is dropped with no result.
        send_item(ACT_SPARE, 8'h55, 8'sd20, 8'sd20, DIR_HORIZ, 8'd4);
        // An empty run draws nothing.
        send_item(ACT_DRAW, 8'h80, 8'sd5, 8'sd5, DIR_HORIZ, 8'd0);
        read_cell(8'sd5, 8'sd5);
        // Runs from the most negative and most positive starts, one reaching into the canvas.
        send_item(ACT_DRAW, 8'h7F, -8'sd128, 8'sd2, DIR_VERT, 8'd255);
        read_cell(8'sd63, 8'sd2);
        send_item(ACT_DRAW, 8'h01, -8'sd128, -8'sd128, DIR_HORIZ, 8'd255);
        send_item(ACT_DRAW, 8'h01, 8'sd127, 8'sd127, DIR_VERT, 8'd255);
        read_cell(8'sd127, 8'sd127);
        read_cell(-8'sd128, -8'sd128);
        read_cell(8'sd64, 8'sd0);
        read_cell(8'sd0, 8'sd64);

        // Random part, one canvas size per phase.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                if (phase < 9) begin
                    set_canvas(row_plan[phase], col_plan[phase]);
                end else begin
                    set_canvas($urandom_range(1, 64), $urandom_range(1, 64));
                end
            end
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (done % 50 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                // Now and then let the results run dry mid-phase.
                if ($urandom_range(0, 199) == 0) begin
                    wait_drained();
                end
                random_item(counted);
                if (counted) begin
                    done++;
                end
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("char_canvas_line_fill_test OK");
        end else begin
            $display("char_canvas_line_fill_test NOT OK");
        end
        $finish;
    end

endmodule
